/* sv/mhpq_pkg.sv */
`default_nettype none
package mhpq_pkg;

  // default heap size
  localparam int unsigned HEAP_DEPTH_DEF = 64;

  // entries in the command queue between front and back, a power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned OCC_W   = 7;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // classified command kinds
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FULL   = 2'd2,
    OP_EMPTY  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic               operation;
    logic [VALUE_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] removed_value;
    logic [OCC_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [VALUE_W-1:0] value;
    logic [OCC_W-1:0]   occupancy;
  } cmd_t;

  // queue to back end handshake
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage
`default_nettype wire

/* sv/mhpq_front.sv */
`default_nettype none
module mhpq_front #(
  parameter int unsigned HeapDepth = mhpq_pkg::HEAP_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  mhpq_pkg::in_item_t  in_item_i,
  output mhpq_pkg::cmd_chan_t cmd_o,
  input  wire                 cmd_pop_i,
  output logic [$clog2(HeapDepth+1)-1:0] count_o
);
  import mhpq_pkg::*;

  localparam int unsigned CW  = $clog2(HeapDepth + 1);
  localparam int unsigned QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]  count_d, count_q;
  cmd_t           cmd_new;
  cmd_t           queue_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] fill_q;
  logic           accept, pop;

  assign in_stall_o = (fill_q == QCW'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = cmd_pop_i && (fill_q != '0);

  // classify against the predicted entry count
  always_comb begin
    count_d       = count_q;
    cmd_new.value = in_item_i.priority_req;
    if (in_item_i.operation == 1'b0) begin
      if (count_q == CW'(HeapDepth)) begin
        cmd_new.kind = OP_FULL;
      end else begin
        cmd_new.kind = OP_INSERT;
        count_d      = count_q + CW'(1);
      end
    end else begin
      if (count_q == '0) begin
        cmd_new.kind = OP_EMPTY;
      end else begin
        cmd_new.kind = OP_REMOVE;
        count_d      = count_q - CW'(1);
      end
    end
    cmd_new.occupancy = OCC_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // command queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + QPW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPW'(1);
      end
      if (accept && !pop) begin
        fill_q <= fill_q + QCW'(1);
      end else if (pop && !accept) begin
        fill_q <= fill_q - QCW'(1);
      end
    end
  end

  assign cmd_o.valid = (fill_q != '0);
  assign cmd_o.cmd   = queue_q[rd_ptr_q];
  assign count_o     = count_q;

endmodule
`default_nettype wire

/* sv/mhpq_engine.sv */
`default_nettype none
module mhpq_engine #(
  parameter int unsigned HeapDepth = mhpq_pkg::HEAP_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mhpq_pkg::cmd_chan_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output mhpq_pkg::out_item_t out_item_o,
  output logic                idle_o,
  output logic [$clog2(HeapDepth+1)-1:0] count_o
);
  import mhpq_pkg::*;

  localparam int unsigned AW = $clog2(HeapDepth);
  localparam int unsigned CW = $clog2(HeapDepth + 1);
  localparam int unsigned IW = AW + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_DEL_RD0 = 3'd3;
  localparam logic [2:0] S_DEL_LD  = 3'd4;
  localparam logic [2:0] S_DEL_RD  = 3'd5;
  localparam logic [2:0] S_DEL_CMP = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]         state_d, state_q;
  logic [CW-1:0]      count_d, count_q;
  logic [AW-1:0]      pos_d, pos_q;
  logic [AW-1:0]      par_d, par_q;
  logic [VALUE_W-1:0] val_d, val_q;
  logic [VALUE_W-1:0] rem_d, rem_q;
  status_e            st_d, st_q;
  logic [OCC_W-1:0]   occ_d, occ_q;

  logic [VALUE_W-1:0] heap_mem [HeapDepth];
  logic [VALUE_W-1:0] rd0_q, rd1_q;
  logic [AW-1:0]      ra0, ra1, waddr;
  logic [VALUE_W-1:0] wdata;
  logic               we;

  logic [IW-1:0]      left, right, last_ext;
  logic               has_right, take_left;
  logic [VALUE_W-1:0] child_val;
  logic [AW-1:0]      child_idx;
  logic               out_free;
  out_item_t          out_q;
  logic               out_valid_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // child indices of the hole during sift-down
  assign left      = {1'b0, pos_q, 1'b1};
  assign right     = left + IW'(1);
  assign last_ext  = IW'(count_q);
  assign has_right = (right < last_ext);
  assign take_left = !has_right || (rd0_q < rd1_q);
  assign child_val = take_left ? rd0_q : rd1_q;
  assign child_idx = take_left ? left[AW-1:0] : right[AW-1:0];

  // sequencer: the moving value stays in val_q, the hole walks the tree
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    par_d     = par_q;
    val_d     = val_q;
    rem_d     = rem_q;
    st_d      = st_q;
    occ_d     = occ_q;
    ra0       = '0;
    ra1       = '0;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = val_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop_o = 1'b1;
          val_d     = cmd_i.cmd.value;
          rem_d     = '0;
          occ_d     = cmd_i.cmd.occupancy;
          st_d      = ST_DONE;
          case (cmd_i.cmd.kind)
            OP_INSERT: begin
              pos_d   = AW'(count_q);
              count_d = count_q + CW'(1);
              state_d = S_INS_RD;
            end
            OP_REMOVE: begin
              count_d = count_q - CW'(1);
              state_d = S_DEL_RD0;
            end
            OP_FULL: begin
              st_d    = ST_FULL;
              state_d = S_OUT;
            end
            default: begin
              st_d    = ST_EMPTY;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_OUT;
        end else begin
          par_d   = (pos_q - AW'(1)) >> 1;
          ra0     = par_d;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rd0_q > val_q) begin
          wdata   = rd0_q;
          pos_d   = par_q;
          state_d = S_INS_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DEL_RD0: begin
        ra0     = '0;
        ra1     = AW'(count_q);
        state_d = S_DEL_LD;
      end
      S_DEL_LD: begin
        rem_d   = rd0_q;
        val_d   = rd1_q;
        pos_d   = '0;
        state_d = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (left >= last_ext) begin
          we      = 1'b1;
          state_d = S_OUT;
        end else begin
          ra0     = left[AW-1:0];
          ra1     = has_right ? right[AW-1:0] : left[AW-1:0];
          state_d = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        we = 1'b1;
        if (child_val < val_q) begin
          wdata   = child_val;
          pos_d   = child_idx;
          state_d = S_DEL_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    par_q <= par_d;
    val_q <= val_d;
    rem_q <= rem_d;
    st_q  <= st_d;
    occ_q <= occ_d;
  end

  // heap memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rd0_q <= heap_mem[ra0];
    rd1_q <= heap_mem[ra1];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q.status        <= st_q;
      out_q.removed_value <= rem_q;
      out_q.occupancy     <= occ_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign idle_o      = (state_q == S_IDLE);
  assign count_o     = count_q;

endmodule
`default_nettype wire

/* sv/min_heap_priority_queue_unit.sv */
// Binary min-heap priority queue of HeapDepth 16-bit values.
// Input channel in_valid_i / in_stall_o / in_item_i: operation 0 inserts
// priority_req, operation 1 removes the minimum. Every item gives exactly
// one result on out_valid_o / out_stall_i / out_item_o: a status (done,
// full, empty), the removed value (zero unless a remove succeeded) and the
// occupancy after the item.
// The front classifies each item against its own entry count and pushes it
// into a two-entry command queue; the back walks the heap in one memory
// with one write and two read ports.
// In the back end a refused item goes straight to the result state; an
// insert climbs from the rear, each level a registered read of the parent
// and a compare, until it reaches the root or stops lower; a remove first
// reads the root and the last entry, then sinks, each level a registered
// read of both children and a compare, until it reaches a leaf or stops.
// The back end takes the next item from the queue only once it is idle.
// Reset empties the heap at once; no clearing pass is needed.
// While out_stall_i is high the result register holds, the back end waits
// with its next result, and the queue keeps taking items until it is full.
`default_nettype none
module min_heap_priority_queue_unit #(
  parameter int unsigned HeapDepth = mhpq_pkg::HEAP_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  mhpq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output mhpq_pkg::out_item_t out_item_o
);
  import mhpq_pkg::*;

  localparam int unsigned CW = $clog2(HeapDepth + 1);

  cmd_chan_t     cmd;
  logic          cmd_pop;
  logic          eng_idle;
  logic [CW-1:0] front_count, back_count;

  mhpq_front #(
    .HeapDepth(HeapDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop),
    .count_o   (front_count)
  );

  mhpq_engine #(
    .HeapDepth(HeapDepth)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .idle_o     (eng_idle),
    .count_o    (back_count)
  );

  // predicted and actual counts agree once the queue has drained
  a_count_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd.valid && eng_idle) |-> (front_count == back_count))
    else $error("front and back entry counts disagree");

  // a full refusal reports a full heap
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_FULL) |->
      (out_item_o.occupancy == OCC_W'(HeapDepth)))
    else $error("full status with wrong occupancy");

  // an empty refusal reports nothing held and nothing removed
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_EMPTY) |->
      (out_item_o.occupancy == '0 && out_item_o.removed_value == '0))
    else $error("empty status with nonzero fields");

endmodule
`default_nettype wire

/* verif/mhpq_checker.sv */
module mhpq_checker #(
  parameter int unsigned Depth = mhpq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  mhpq_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mhpq_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  // shadow heap, entries at or above heap_count are never read
  logic [VALUE_W-1:0] heap_model [Depth];
  int unsigned        heap_count;
  out_item_t          expected_results_q [$];
  int                 fails = 0;

  // apply one item to the shadow heap and return the result it gives
  function automatic out_item_t apply_heap_op(input in_item_t item);
    out_item_t          res;
    int unsigned        pos;
    int unsigned        parent;
    int unsigned        left;
    int unsigned        right;
    int unsigned        pick;
    logic [VALUE_W-1:0] tmp;
    bit                 walking;
    res.status        = ST_DONE;
    res.removed_value = '0;
    if (cmd_kind_e'({1'b0, item.operation}) == OP_INSERT) begin
      if (heap_count >= Depth) begin
        res.status = ST_FULL;
      end else begin
        // place at the rear, then climb past strictly larger parents
        heap_model[heap_count] = item.priority_req;
        pos = heap_count;
        heap_count++;
        walking = 1'b1;
        while (walking && pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_model[parent] > heap_model[pos]) begin
            tmp                = heap_model[parent];
            heap_model[parent] = heap_model[pos];
            heap_model[pos]    = tmp;
            pos                = parent;
          end else begin
            walking = 1'b0;
          end
        end
      end
    end else begin
      if (heap_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // take the root, move the last entry up and sink it
        res.removed_value = heap_model[0];
        heap_model[0] = heap_model[heap_count-1];
        heap_count--;
        pos = 0;
        walking = 1'b1;
        while (walking) begin
          left  = 2 * pos + 1;
          right = left + 1;
          if (left >= heap_count) begin
            walking = 1'b0;
          end else begin
            // equal children: the right one wins
            if (right >= heap_count || heap_model[left] < heap_model[right]) begin
              pick = left;
            end else begin
              pick = right;
            end
            if (heap_model[pick] < heap_model[pos]) begin
              tmp              = heap_model[pick];
              heap_model[pick] = heap_model[pos];
              heap_model[pos]  = tmp;
              pos              = pick;
            end else begin
              walking = 1'b0;
            end
          end
        end
      end
    end
    res.occupancy = OCC_W'(heap_count);
    return res;
  endfunction

  // predict on accepted input items, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      heap_count = 0;
      expected_results_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results_q.push_back(apply_heap_op(in_item_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          fails++;
          $display("%0t ns: result with nothing expected, expected none, actual %0d/%0h/%0d",
                   $time, out_item_i.status, out_item_i.removed_value,
                   out_item_i.occupancy);
        end else begin
          exp_item = expected_results_q.pop_front();
          if (out_item_i.status !== exp_item.status) begin
            fails++;
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, exp_item.status, out_item_i.status);
          end
          if (out_item_i.removed_value !== exp_item.removed_value) begin
            fails++;
            $display("%0t ns: removed_value mismatch, expected %0h, actual %0h",
                     $time, exp_item.removed_value, out_item_i.removed_value);
          end
          if (out_item_i.occupancy !== exp_item.occupancy) begin
            fails++;
            $display("%0t ns: occupancy mismatch, expected %0d, actual %0d",
                     $time, exp_item.occupancy, out_item_i.occupancy);
          end
        end
      end
      pending_o <= expected_results_q.size();
    end
    fail_count_o <= fails;
  end

  // expectations left over at the end count as failures through pending_o
endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  localparam int unsigned DEPTH        = HEAP_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 32;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BLOCKS
  } stall_mode_e;

  typedef enum int {
    PH_MIXED,
    PH_FILL,
    PH_DRAIN,
    PH_FULL_CYCLE
  } phase_e;

  typedef enum int {
    VAL_FULL,
    VAL_NARROW,
    VAL_EDGE
  } value_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b0;
  bit          draining    = 1'b0;
  int unsigned idle_cycles = 0;
  stall_mode_e stall_mode  = STALL_NONE;
  int unsigned stall_left  = 0;

  always #1 clk = ~clk;

  min_heap_priority_queue_unit #(
    .HeapDepth(DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  mhpq_checker #(
    .Depth(DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic in_item_t make_item(input cmd_kind_e kind, input logic [VALUE_W-1:0] value);
    in_item_t item;
    item.operation    = (kind == OP_REMOVE);
    item.priority_req = value;
    return item;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input value_mode_e mode);
    logic [VALUE_W-1:0] v;
    case (mode)
      VAL_NARROW: v = VALUE_W'($urandom_range(0, 7));
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = 16'h0001;
          2:       v = 16'hFFFE;
          default: v = '1;
        endcase
      end
      default: v = VALUE_W'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  // present one item, wait for it to be taken, then maybe idle between bursts
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 8);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // receiver stall pattern, switching to a random mode at random intervals
  always @(posedge clk) begin
    if (draining) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        stall_left <= $urandom_range(16, 160);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        STALL_BLOCKS: out_stall <= stall_left[3];
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    phase_e      phase;
    value_mode_e vmode;
    int unsigned n;
    cmd_kind_e   kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty remove, extreme and tied values, drain to empty
    send_item(make_item(OP_REMOVE, 16'hFFFF));
    send_item(make_item(OP_INSERT, 16'hFFFF));
    send_item(make_item(OP_INSERT, 16'h0000));
    send_item(make_item(OP_INSERT, 16'h8000));
    send_item(make_item(OP_INSERT, 16'h7FFF));
    send_item(make_item(OP_INSERT, 16'h0001));
    send_item(make_item(OP_INSERT, 16'h1234));
    send_item(make_item(OP_INSERT, 16'h1234));
    send_item(make_item(OP_INSERT, 16'h0000));
    repeat (8) send_item(make_item(OP_REMOVE, 16'hAAAA));
    send_item(make_item(OP_REMOVE, 16'h5555));

    // random phases of mixed, fill-heavy, drain-heavy and full cycles
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase   = phase_e'($urandom_range(0, 3));
      vmode   = value_mode_e'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      case (phase)
        PH_FILL: begin
          repeat ($urandom_range(20, 80)) begin
            kind = ($urandom_range(0, 4) == 0) ? OP_REMOVE : OP_INSERT;
            send_item(make_item(kind, pick_value(vmode)));
          end
        end
        PH_DRAIN: begin
          repeat ($urandom_range(20, 80)) begin
            kind = ($urandom_range(0, 4) == 0) ? OP_INSERT : OP_REMOVE;
            send_item(make_item(kind, pick_value(vmode)));
          end
        end
        PH_FULL_CYCLE: begin
          n = DEPTH + $urandom_range(1, 6);
          repeat (n) send_item(make_item(OP_INSERT, pick_value(vmode)));
          n = DEPTH + $urandom_range(1, 6);
          repeat (n) send_item(make_item(OP_REMOVE, pick_value(VAL_FULL)));
        end
        default: begin
          repeat ($urandom_range(20, 80)) begin
            kind = ($urandom_range(0, 1) == 1) ? OP_REMOVE : OP_INSERT;
            send_item(make_item(kind, pick_value(vmode)));
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    // wait for every expected result, then let the block settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    draining <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/mhpq_pkg.sv
sv/mhpq_front.sv
sv/mhpq_engine.sv
sv/min_heap_priority_queue_unit.sv
verif/mhpq_checker.sv
verif/tb_top.sv
